// ----- src/ddpid_pkg.sv -----
// Shared types, widths and codes for the differential drive PID position block.
`default_nettype none

package ddpid_pkg;

   // Field and datapath widths
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int GAIN_FRAC_BITS  = 8;
   localparam int FIELD_W         = 32;
   localparam int ACTION_W        = 2;
   localparam int SP_W            = 32;
   localparam int ERR_W           = 34;
   localparam int INTEG_W         = 48;
   localparam int GAIN_W          = 16;
   localparam int LIMIT_W         = 15;
   localparam int BAND_W          = 8;
   localparam int CMD_W           = 16;
   localparam int DRIVE_W         = 17;
   localparam int TERM_LIM_LOG2   = 60;
   localparam int TERM_W          = TERM_LIM_LOG2 + 2;

   // CSR port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_TRANS = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ADD_ROT   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_STOP      = 2'd3;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_TRANS_KP = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TRANS_KI = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TRANS_KD = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ROT_KP   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ROT_KI   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ROT_KD   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_BAND     = 3'd7;

   // Register reset values
   localparam logic [GAIN_W-1:0]  RST_KP    = 16'd256;
   localparam logic [GAIN_W-1:0]  RST_KI    = 16'd0;
   localparam logic [GAIN_W-1:0]  RST_KD    = 16'd0;
   localparam logic [LIMIT_W-1:0] RST_LIMIT = 15'd255;
   localparam logic [BAND_W-1:0]  RST_BAND  = 8'd10;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gain_type;

   typedef struct packed {
      gain_type             trans;
      gain_type             rot;
      logic [LIMIT_W-1:0]   limit;
      logic [BAND_W-1:0]    band;
   } cfg_type;

   // Per-loop pipeline control from the top level
   typedef struct packed {
      logic tick;     // tick leaves the input stage: update state, load stage B
      logic sp_add;   // add delta to this loop's setpoint
      logic sp_load;  // snap setpoint to the measured position
      logic c_en;     // product stage advances
      logic e_en;     // command stage advances
   } loop_ctl_type;

endpackage

`default_nettype wire

// ----- src/ddpid_if.sv -----
// Request and response channel interfaces.
`default_nettype none

interface ddpid_req_if;
   import ddpid_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [ACTION_W-1:0]         action;
   logic signed [FIELD_W-1:0]   left_count;
   logic signed [FIELD_W-1:0]   right_count;
   logic signed [FIELD_W-1:0]   setpoint_delta;

   modport source (output valid, action, left_count, right_count, setpoint_delta,
                   input ready);
   modport sink   (input valid, action, left_count, right_count, setpoint_delta,
                   output ready);
endinterface

interface ddpid_rsp_if;
   import ddpid_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [DRIVE_W-1:0]   right_drive;
   logic signed [DRIVE_W-1:0]   left_drive;
   logic                        at_rest;

   modport source (output valid, right_drive, left_drive, at_rest, input ready);
   modport sink   (input valid, right_drive, left_drive, at_rest, output ready);
endinterface

`default_nettype wire

// ----- src/differential_drive_pid_position.sv -----
// Top level of the two-loop PID position controller for a differential drive.
//
// Usage:
//  - req channel (valid/ready) carries action, left_count, right_count and
//    setpoint_delta. A tick runs both PID loops and yields one rsp transaction;
//    add-translation, add-rotation and stop only update setpoints, no response.
//  - rsp channel (valid/ready) carries right_drive, left_drive and at_rest.
//  - csr_* is an APB-style port; register i sits at byte address 4*i. Write it
//    only while no transaction is in flight.
//  - Pipeline: a tick passes through the input register, error/integral
//    stage, product stage, command stage and output register before its
//    response shows.
//  - Throughput: one transaction per cycle, any mix of actions, while rsp is
//    not stalled. Integral, previous error and setpoint update as an item
//    leaves stage A, so back-to-back ticks see each other's state.
//  - Stall: a stage holds only while the next is full and held, so bubbles are
//    squeezed out; req_if.ready drops only once every stage is full and the
//    output register is stalled.
//  - Reset (synchronous): setpoints, integrals and previous errors go to zero,
//    registers to their defaults, and all stages empty.
`default_nettype none

module differential_drive_pid_position #(
   parameter int COUNT_WIDTH = ddpid_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ddpid_req_if.sink                             req_if,
   ddpid_rsp_if.source                           rsp_if,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ddpid_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ddpid_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ddpid_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import ddpid_pkg::*;

   localparam int MEAS_W = COUNT_WIDTH + 1;

   cfg_type cfg;

   // Stage A: input register. L+R and L-R are formed on the way in.
   logic                       a_valid_ff;
   logic [ACTION_W-1:0]        a_action_ff;
   logic signed [MEAS_W-1:0]   a_sum_ff, a_diff_ff;
   logic signed [SP_W-1:0]     a_delta_ff;
   logic signed [COUNT_WIDTH-1:0] left_cnt, right_cnt;
   logic                       a_en;

   // Pipeline valids and advance enables
   logic b_valid_ff, c_valid_ff, e_valid_ff;
   logic b_en, c_en, e_en, out_en;

   loop_ctl_type trans_ctl, rot_ctl;
   logic signed [CMD_W-1:0] trans_cmd, rot_cmd;
   logic a_go;

   ddpid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // encoder counts: low COUNT_WIDTH bits, sign-extended
   assign left_cnt  = req_if.left_count[COUNT_WIDTH-1:0];
   assign right_cnt = req_if.right_count[COUNT_WIDTH-1:0];

   // ready chain: a stage advances when it is empty or the next one advances
   assign e_en      = !e_valid_ff || out_en;
   assign c_en      = !c_valid_ff || e_en;
   assign b_en      = !b_valid_ff || c_en;
   assign a_en      = !a_valid_ff || b_en;
   assign req_if.ready = a_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en && req_if.valid) begin
         a_action_ff <= req_if.action;
         a_sum_ff    <= MEAS_W'(left_cnt) + MEAS_W'(right_cnt);
         a_diff_ff   <= MEAS_W'(left_cnt) - MEAS_W'(right_cnt);
         a_delta_ff  <= req_if.setpoint_delta;
      end
   end

   // item leaves stage A this cycle; only ticks travel further
   assign a_go = a_valid_ff && b_en;

   always_comb begin
      trans_ctl.tick    = a_go && (a_action_ff == ACT_TICK);
      trans_ctl.sp_add  = a_go && (a_action_ff == ACT_ADD_TRANS);
      trans_ctl.sp_load = a_go && (a_action_ff == ACT_STOP);
      trans_ctl.c_en    = c_en;
      trans_ctl.e_en    = e_en;
      rot_ctl.tick      = trans_ctl.tick;
      rot_ctl.sp_add    = a_go && (a_action_ff == ACT_ADD_ROT);
      rot_ctl.sp_load   = trans_ctl.sp_load;
      rot_ctl.c_en      = c_en;
      rot_ctl.e_en      = e_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (b_en) begin
            b_valid_ff <= a_valid_ff && (a_action_ff == ACT_TICK);
         end
         if (c_en) begin
            c_valid_ff <= b_valid_ff;
         end
         if (e_en) begin
            e_valid_ff <= c_valid_ff;
         end
      end
   end

   // translation loop works on L+R, rotation loop on L-R
   ddpid_loop #(.MEAS_W(MEAS_W)) u_trans_loop (
      .clock (clock),
      .reset (reset),
      .ctl   (trans_ctl),
      .meas  (a_sum_ff),
      .delta (a_delta_ff),
      .gains (cfg.trans),
      .limit (cfg.limit),
      .cmd   (trans_cmd)
   );

   ddpid_loop #(.MEAS_W(MEAS_W)) u_rot_loop (
      .clock (clock),
      .reset (reset),
      .ctl   (rot_ctl),
      .meas  (a_diff_ff),
      .delta (a_delta_ff),
      .gains (cfg.rot),
      .limit (cfg.limit),
      .cmd   (rot_cmd)
   );

   ddpid_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (e_valid_ff),
      .in_ready    (out_en),
      .trans_cmd   (trans_cmd),
      .rot_cmd     (rot_cmd),
      .band        (cfg.band),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .right_drive (rsp_if.right_drive),
      .left_drive  (rsp_if.left_drive),
      .at_rest     (rsp_if.at_rest)
   );

   // a new response only ever comes from a full command stage
   a_rsp_from_cmd: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(e_valid_ff))
      else $error("response raised without a command stage transaction");

   // setpoint-only actions never enter the PID pipeline
   a_no_result_for_setpoint: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && b_en && (a_action_ff != ACT_TICK)) |=> !b_valid_ff)
      else $error("setpoint action leaked into the PID pipeline");

   // input is refused only when every stage is full and the output is stalled
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (a_valid_ff && b_valid_ff && c_valid_ff && e_valid_ff
                         && rsp_if.valid && !rsp_if.ready))
      else $error("input stalled with room in the pipeline");

   // at most one loop state update per cycle, and only from a tick in stage A
   a_state_update_from_tick: assert property (@(posedge clock) disable iff (reset)
      trans_ctl.tick |-> (a_valid_ff && !trans_ctl.sp_add && !trans_ctl.sp_load
                          && !rot_ctl.sp_add))
      else $error("conflicting loop state updates");

endmodule

`default_nettype wire

// ----- src/ddpid_csr.sv -----
// APB-style configuration register file.
`default_nettype none

module ddpid_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ddpid_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ddpid_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ddpid_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready,
   output ddpid_pkg::cfg_type                    cfg
);
   import ddpid_pkg::*;

   cfg_type                cfg_ff;
   logic [REG_IDX_W-1:0]   idx;
   logic                   wr;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trans.kp <= RST_KP;
         cfg_ff.trans.ki <= RST_KI;
         cfg_ff.trans.kd <= RST_KD;
         cfg_ff.rot.kp   <= RST_KP;
         cfg_ff.rot.ki   <= RST_KI;
         cfg_ff.rot.kd   <= RST_KD;
         cfg_ff.limit    <= RST_LIMIT;
         cfg_ff.band     <= RST_BAND;
      end else if (wr) begin
         unique case (idx)
            REG_TRANS_KP: cfg_ff.trans.kp <= csr_pwdata[GAIN_W-1:0];
            REG_TRANS_KI: cfg_ff.trans.ki <= csr_pwdata[GAIN_W-1:0];
            REG_TRANS_KD: cfg_ff.trans.kd <= csr_pwdata[GAIN_W-1:0];
            REG_ROT_KP:   cfg_ff.rot.kp   <= csr_pwdata[GAIN_W-1:0];
            REG_ROT_KI:   cfg_ff.rot.ki   <= csr_pwdata[GAIN_W-1:0];
            REG_ROT_KD:   cfg_ff.rot.kd   <= csr_pwdata[GAIN_W-1:0];
            REG_LIMIT:    cfg_ff.limit    <= csr_pwdata[LIMIT_W-1:0];
            REG_BAND:     cfg_ff.band     <= csr_pwdata[BAND_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_TRANS_KP: csr_prdata = CSR_DATA_W'(cfg_ff.trans.kp);
         REG_TRANS_KI: csr_prdata = CSR_DATA_W'(cfg_ff.trans.ki);
         REG_TRANS_KD: csr_prdata = CSR_DATA_W'(cfg_ff.trans.kd);
         REG_ROT_KP:   csr_prdata = CSR_DATA_W'(cfg_ff.rot.kp);
         REG_ROT_KI:   csr_prdata = CSR_DATA_W'(cfg_ff.rot.ki);
         REG_ROT_KD:   csr_prdata = CSR_DATA_W'(cfg_ff.rot.kd);
         REG_LIMIT:    csr_prdata = CSR_DATA_W'(cfg_ff.limit);
         REG_BAND:     csr_prdata = CSR_DATA_W'(cfg_ff.band);
      endcase
   end

endmodule

`default_nettype wire

// ----- src/ddpid_loop.sv -----
// One PID loop: setpoint, error/integral state, gain products and clamped command.
`default_nettype none

module ddpid_loop #(
   parameter int MEAS_W = ddpid_pkg::COUNT_WIDTH_DEF + 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ddpid_pkg::loop_ctl_type               ctl,
   input  logic signed [MEAS_W-1:0]              meas,
   input  logic signed [ddpid_pkg::SP_W-1:0]     delta,
   input  ddpid_pkg::gain_type                   gains,
   input  logic [ddpid_pkg::LIMIT_W-1:0]         limit,
   output logic signed [ddpid_pkg::CMD_W-1:0]    cmd
);
   import ddpid_pkg::*;

   localparam int DERIV_W  = ERR_W + 1;
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
   localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
   localparam int SUM_W    = TERM_W + 1;

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
   localparam logic signed [PROD_I_W-1:0] TERM_MAX =
      {{(PROD_I_W-TERM_LIM_LOG2-1){1'b0}}, 1'b1, {TERM_LIM_LOG2{1'b0}}};
   localparam logic signed [PROD_I_W-1:0] TERM_MIN = -TERM_MAX;

   // state
   logic signed [SP_W-1:0]     sp_ff;
   logic signed [INTEG_W-1:0]  integ_ff;
   logic signed [ERR_W-1:0]    prev_ff;

   // stage B
   logic signed [ERR_W-1:0]    err;
   logic signed [INTEG_W:0]    integ_sum;
   logic signed [INTEG_W-1:0]  integ_new;
   logic signed [DERIV_W-1:0]  deriv;
   logic signed [ERR_W-1:0]    err_b_ff;
   logic signed [INTEG_W-1:0]  integ_b_ff;
   logic signed [DERIV_W-1:0]  deriv_b_ff;

   // stage C
   logic signed [GAIN_W:0]     kp_s, ki_s, kd_s;
   logic signed [PROD_P_W-1:0] prod_p;
   logic signed [PROD_I_W-1:0] prod_i;
   logic signed [PROD_D_W-1:0] prod_d;
   logic signed [TERM_W-1:0]   term_i;
   logic signed [PROD_P_W-1:0] p_c_ff;
   logic signed [TERM_W-1:0]   i_c_ff;
   logic signed [PROD_D_W-1:0] d_c_ff;

   // stage E
   logic signed [SUM_W-1:0]    pid_sum;
   logic signed [SUM_W-1:0]    shifted;
   logic signed [SUM_W-1:0]    lim_s;
   logic signed [SUM_W-1:0]    clamped;
   logic signed [CMD_W-1:0]    cmd_ff;

   always_comb begin
      err       = ERR_W'(sp_ff) - ERR_W'(meas);
      integ_sum = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'(err);
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_new = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_new = integ_sum[INTEG_W-1:0];
      end
      deriv = DERIV_W'(err) - DERIV_W'(prev_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= '0;
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         if (ctl.sp_load) begin
            sp_ff <= SP_W'(meas);
         end else if (ctl.sp_add) begin
            sp_ff <= sp_ff + delta;
         end
         if (ctl.tick) begin
            integ_ff <= integ_new;
            prev_ff  <= err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.tick) begin
         err_b_ff   <= err;
         integ_b_ff <= integ_new;
         deriv_b_ff <= deriv;
      end
   end

   // gain products; integral term pre-clamped to +-2^60
   always_comb begin
      kp_s   = $signed({1'b0, gains.kp});
      ki_s   = $signed({1'b0, gains.ki});
      kd_s   = $signed({1'b0, gains.kd});
      prod_p = PROD_P_W'(kp_s) * PROD_P_W'(err_b_ff);
      prod_i = PROD_I_W'(ki_s) * PROD_I_W'(integ_b_ff);
      prod_d = PROD_D_W'(kd_s) * PROD_D_W'(deriv_b_ff);
      if (prod_i > TERM_MAX) begin
         term_i = TERM_W'(TERM_MAX);
      end else if (prod_i < TERM_MIN) begin
         term_i = TERM_W'(TERM_MIN);
      end else begin
         term_i = TERM_W'(prod_i);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.c_en) begin
         p_c_ff <= prod_p;
         i_c_ff <= term_i;
         d_c_ff <= prod_d;
      end
   end

   // sum, floor shift, symmetric clamp
   always_comb begin
      pid_sum = SUM_W'(p_c_ff) + SUM_W'(i_c_ff) + SUM_W'(d_c_ff);
      shifted = pid_sum >>> GAIN_FRAC_BITS;
      lim_s   = SUM_W'($signed({1'b0, limit}));
      if (shifted > lim_s) begin
         clamped = lim_s;
      end else if (shifted < -lim_s) begin
         clamped = -lim_s;
      end else begin
         clamped = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.e_en) begin
         cmd_ff <= CMD_W'(clamped);
      end
   end

   assign cmd = cmd_ff;

endmodule

`default_nettype wire

// ----- src/ddpid_mix.sv -----
// Output stage: mixes loop commands into wheel drives, applies deadband, holds the result.
`default_nettype none

module ddpid_mix (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [ddpid_pkg::CMD_W-1:0]    trans_cmd,
   input  logic signed [ddpid_pkg::CMD_W-1:0]    rot_cmd,
   input  logic [ddpid_pkg::BAND_W-1:0]          band,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [ddpid_pkg::DRIVE_W-1:0]  right_drive,
   output logic signed [ddpid_pkg::DRIVE_W-1:0]  left_drive,
   output logic                                  at_rest
);
   import ddpid_pkg::*;

   function automatic logic signed [DRIVE_W-1:0] apply_band(
      input logic signed [DRIVE_W-1:0] v,
      input logic [BAND_W-1:0]         b
   );
      logic [DRIVE_W-1:0] mag;
      mag = v[DRIVE_W-1] ? DRIVE_W'(-v) : DRIVE_W'(v);
      return (mag < DRIVE_W'(b)) ? '0 : v;
   endfunction

   logic                       valid_ff;
   logic signed [DRIVE_W-1:0]  right_ff, left_ff;
   logic                       rest_ff;
   logic signed [DRIVE_W-1:0]  right_in, left_in;
   logic                       rest_in;

   always_comb begin
      right_in = apply_band(DRIVE_W'(trans_cmd) - DRIVE_W'(rot_cmd), band);
      left_in  = apply_band(DRIVE_W'(trans_cmd) + DRIVE_W'(rot_cmd), band);
      rest_in  = (right_in == '0) && (left_in == '0);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         right_ff <= right_in;
         left_ff  <= left_in;
         rest_ff  <= rest_in;
      end
   end

   assign out_valid   = valid_ff;
   assign right_drive = right_ff;
   assign left_drive  = left_ff;
   assign at_rest     = rest_ff;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the differential drive PID position controller.

module testbench;
   import ddpid_pkg::*;

   // Cycles to let the pipeline empty out before touching registers or ending.
   localparam int SETTLE_CYCLES = 10;
   // Hard stop for a hung run, in time units (clock period is 2).
   localparam int RUN_LIMIT = 400000;
   // Cap on printed mismatch lines; every mismatch is still counted.
   localparam int PRINT_CAP = 50;

   localparam logic signed [FIELD_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [FIELD_W-1:0] POS_MIN = 32'sh8000_0000;
   localparam longint INTEG_TOP = (longint'(1) <<< (INTEG_W - 1)) - 1;
   localparam longint TERM_TOP  = longint'(1) <<< TERM_LIM_LOG2;

   // One request transaction: an action with its encoder counts and delta.
   typedef struct {
      logic [ACTION_W-1:0]       action;
      logic signed [FIELD_W-1:0] left_count;
      logic signed [FIELD_W-1:0] right_count;
      logic signed [FIELD_W-1:0] setpoint_delta;
   } move_type;

   // One response transaction: the two motor drives and the rest flag.
   typedef struct {
      logic signed [DRIVE_W-1:0] right_drive;
      logic signed [DRIVE_W-1:0] left_drive;
      logic                      at_rest;
   } drive_type;

   // Receiver back-pressure styles.
   typedef enum int {RX_EAGER, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   logic clock;
   logic reset;

   ddpid_req_if req_if();
   ddpid_rsp_if rsp_if();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   differential_drive_pid_position dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the controller: registers, setpoints, loop memories.
   // ---------------------------------------------------------------------
   cfg_type                shadow_cfg;
   logic signed [SP_W-1:0] trans_sp;
   logic signed [SP_W-1:0] rot_sp;
   longint                 trans_integ;
   longint                 rot_integ;
   longint                 trans_prev;
   longint                 rot_prev;

   move_type  cmd_backlog[$];     // request transactions waiting for the driver
   drive_type pending_drives[$];  // drives predicted, not yet seen on rsp
   drive_type want_drive;

   int moves_queued    = 0;
   int moves_accepted  = 0;
   int ticks_accepted  = 0;
   int drives_checked  = 0;
   int rest_seen       = 0;
   int mismatches      = 0;
   int settings_loaded = 0;

   // Sender burst shaping and receiver stall pattern.
   int          burst_left;
   int          gap_left;
   rx_mode_type stall_mode;
   int          mode_left;
   int          stall_tick;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("MISMATCH %0d (drive transaction %0d): %s", mismatches, drives_checked, what);
   endtask

   // One PID loop: integral saturates at 48 bits, the integral term is
   // bounded at 2^60, the sum is floored by the Q8.8 fraction and clamped.
   function automatic longint pid_command(input longint err, inout longint integ,
                                          inout longint prev, input logic [GAIN_W-1:0] kp,
                                          input logic [GAIN_W-1:0] ki,
                                          input logic [GAIN_W-1:0] kd);
      longint slope;
      longint term;
      longint sum;
      longint limit;
      limit = longint'(shadow_cfg.limit);
      slope = err - prev;
      integ = integ + err;
      if (integ > INTEG_TOP)
         integ = INTEG_TOP;
      else if (integ < -INTEG_TOP - 1)
         integ = -INTEG_TOP - 1;
      prev = err;
      term = longint'(ki) * integ;
      if (term > TERM_TOP)
         term = TERM_TOP;
      else if (term < -TERM_TOP)
         term = -TERM_TOP;
      sum = (term + longint'(kp) * err + longint'(kd) * slope) >>> GAIN_FRAC_BITS;
      if (sum > limit)
         sum = limit;
      else if (sum < -limit)
         sum = -limit;
      return sum;
   endfunction

   // Drives with magnitude under the deadband are forced to zero.
   function automatic longint band_gate(input longint v);
      longint mag;
      mag = (v < 0) ? -v : v;
      return (mag < longint'(shadow_cfg.band)) ? 0 : v;
   endfunction

   // Applies one accepted transaction to the shadow; returns 1 with the
   // expected drives when the transaction is a tick.
   function automatic bit advance_controller(input move_type mv, output drive_type res);
      longint sum_pos;
      longint diff_pos;
      longint tr;
      longint th;
      longint rd;
      longint ld;
      sum_pos  = longint'(mv.left_count) + longint'(mv.right_count);
      diff_pos = longint'(mv.left_count) - longint'(mv.right_count);
      res = '{default: '0};
      case (mv.action)
         ACT_ADD_TRANS: trans_sp = trans_sp + mv.setpoint_delta;
         ACT_ADD_ROT:   rot_sp = rot_sp + mv.setpoint_delta;
         ACT_STOP: begin
            trans_sp = sum_pos[SP_W-1:0];
            rot_sp   = diff_pos[SP_W-1:0];
         end
         ACT_TICK: begin
            tr = pid_command(longint'(trans_sp) - sum_pos, trans_integ, trans_prev,
                             shadow_cfg.trans.kp, shadow_cfg.trans.ki, shadow_cfg.trans.kd);
            th = pid_command(longint'(rot_sp) - diff_pos, rot_integ, rot_prev,
                             shadow_cfg.rot.kp, shadow_cfg.rot.ki, shadow_cfg.rot.kd);
            rd = band_gate(tr - th);
            ld = band_gate(tr + th);
            res.right_drive = rd[DRIVE_W-1:0];
            res.left_drive  = ld[DRIVE_W-1:0];
            res.at_rest     = (rd == 0) && (ld == 0);
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Clock.
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(RUN_LIMIT);
      $display("Timed out, %0d drive transactions still expected", pending_drives.size());
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps. The
   // prediction is taken at the edge that accepts the transaction, straight
   // from the values on the channel.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid          <= 1'b0;
         req_if.action         <= ACT_TICK;
         req_if.left_count     <= '0;
         req_if.right_count    <= '0;
         req_if.setpoint_delta <= '0;
         burst_left            <= 0;
         gap_left              <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            move_type  seen;
            drive_type outcome;
            seen.action         = req_if.action;
            seen.left_count     = req_if.left_count;
            seen.right_count    = req_if.right_count;
            seen.setpoint_delta = req_if.setpoint_delta;
            if (advance_controller(seen, outcome)) begin
               pending_drives.push_back(outcome);
               ticks_accepted++;
            end
            moves_accepted++;
         end
         // Slot is free when nothing is held or the held one just went.
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left     <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               move_type nxt;
               nxt = cmd_backlog.pop_front();
               req_if.action         <= nxt.action;
               req_if.left_count     <= nxt.left_count;
               req_if.right_count    <= nxt.right_count;
               req_if.setpoint_delta <= nxt.setpoint_delta;
               req_if.valid          <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 16);
                  // About one burst in three is followed by a pause.
                  gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor and receiver stall pattern. Each accepted drive
   // transaction is checked field by field against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_mode   <= RX_EAGER;
         mode_left    <= 0;
         stall_tick   <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_drives.size() == 0) begin
               report_mismatch("drive transaction with nothing expected");
            end else begin
               want_drive = pending_drives.pop_front();
               if (rsp_if.right_drive !== want_drive.right_drive)
                  report_mismatch($sformatf("right_drive got %0d want %0d",
                                            rsp_if.right_drive, want_drive.right_drive));
               if (rsp_if.left_drive !== want_drive.left_drive)
                  report_mismatch($sformatf("left_drive got %0d want %0d",
                                            rsp_if.left_drive, want_drive.left_drive));
               if (rsp_if.at_rest !== want_drive.at_rest)
                  report_mismatch($sformatf("at_rest got %b want %b",
                                            rsp_if.at_rest, want_drive.at_rest));
               if (want_drive.at_rest)
                  rest_seen++;
            end
            drives_checked++;
         end
         // Stall style is redrawn whenever its random hold count runs out.
         if (mode_left == 0) begin
            stall_mode <= rx_mode_type'($urandom_range(0, 2));
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         stall_tick <= stall_tick + 1;
         case (stall_mode)
            RX_EAGER:  rsp_if.ready <= 1'b1;
            RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 2) != 0);
            default:   rsp_if.ready <= ((stall_tick % 5) < 3);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   task automatic queue_move(input logic [ACTION_W-1:0] act,
                             input logic signed [FIELD_W-1:0] lc,
                             input logic signed [FIELD_W-1:0] rc,
                             input logic signed [FIELD_W-1:0] delta);
      move_type mv;
      mv.action         = act;
      mv.left_count     = lc;
      mv.right_count    = rc;
      mv.setpoint_delta = delta;
      cmd_backlog.push_back(mv);
      moves_queued++;
   endtask

   function automatic int jitter(input int spread);
      return int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // Waits until every queued transaction went in and every drive came out,
   // then lets the pipeline settle.
   task automatic drain();
      while (moves_accepted != moves_queued || pending_drives.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the register takes the value
   // at the edge where psel, penable, pwrite and pready are all high.
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // Shadow keeps only the register's own width.
      case (idx)
         REG_TRANS_KP: shadow_cfg.trans.kp = value[GAIN_W-1:0];
         REG_TRANS_KI: shadow_cfg.trans.ki = value[GAIN_W-1:0];
         REG_TRANS_KD: shadow_cfg.trans.kd = value[GAIN_W-1:0];
         REG_ROT_KP:   shadow_cfg.rot.kp   = value[GAIN_W-1:0];
         REG_ROT_KI:   shadow_cfg.rot.ki   = value[GAIN_W-1:0];
         REG_ROT_KD:   shadow_cfg.rot.kd   = value[GAIN_W-1:0];
         REG_LIMIT:    shadow_cfg.limit    = value[LIMIT_W-1:0];
         REG_BAND:     shadow_cfg.band     = value[BAND_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] t_kp, t_ki, t_kd,
                                input logic [CSR_DATA_W-1:0] r_kp, r_ki, r_kd,
                                input logic [CSR_DATA_W-1:0] lim, band);
      write_reg(REG_TRANS_KP, t_kp);
      write_reg(REG_TRANS_KI, t_ki);
      write_reg(REG_TRANS_KD, t_kd);
      write_reg(REG_ROT_KP, r_kp);
      write_reg(REG_ROT_KI, r_ki);
      write_reg(REG_ROT_KD, r_kd);
      write_reg(REG_LIMIT, lim);
      write_reg(REG_BAND, band);
      settings_loaded++;
   endtask

   // Mostly realistic motion: stop at a position, nudge setpoints, tick with
   // encoders wandering around that position. The rest is raw noise.
   task automatic run_random(input int count, input int spread);
      int base_l;
      int base_r;
      int pick;
      base_l = jitter(1000);
      base_r = jitter(1000);
      queue_move(ACT_STOP, base_l, base_r, $urandom);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            queue_move(ACTION_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
         end else if (pick < 14) begin
            if ($urandom_range(0, 2) == 0) begin
               base_l = $urandom;
               base_r = $urandom;
            end else begin
               base_l = jitter(1000000);
               base_r = jitter(1000000);
            end
            queue_move(ACT_STOP, base_l, base_r, $urandom);
         end else if (pick < 24) begin
            queue_move(ACT_ADD_TRANS, $urandom, $urandom, jitter(spread));
         end else if (pick < 32) begin
            queue_move(ACT_ADD_ROT, $urandom, $urandom, jitter(spread));
         end else begin
            base_l = base_l + jitter(spread / 8 + 1);
            base_r = base_r + jitter(spread / 8 + 1);
            queue_move(ACT_TICK, base_l + jitter(spread), base_r + jitter(spread), $urandom);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      shadow_cfg.trans.kp = RST_KP;
      shadow_cfg.trans.ki = RST_KI;
      shadow_cfg.trans.kd = RST_KD;
      shadow_cfg.rot.kp   = RST_KP;
      shadow_cfg.rot.ki   = RST_KI;
      shadow_cfg.rot.kd   = RST_KD;
      shadow_cfg.limit    = RST_LIMIT;
      shadow_cfg.band     = RST_BAND;
      trans_sp    = '0;
      rot_sp      = '0;
      trans_integ = 0;
      rot_integ   = 0;
      trans_prev  = 0;
      rot_prev    = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed, on reset register values (unity Kp, limit 255, band 10).
      queue_move(ACT_TICK, 0, 0, 0);                 // zero error: at rest
      queue_move(ACT_ADD_TRANS, 0, 0, 100);
      queue_move(ACT_TICK, 0, 0, 0);                 // pure translation
      queue_move(ACT_ADD_ROT, 0, 0, -40);
      queue_move(ACT_TICK, 0, 0, 0);                 // drives split by rotation
      queue_move(ACT_TICK, 50, 50, 0);               // translation cancels
      queue_move(ACT_STOP, 3, -3, 0);
      queue_move(ACT_TICK, 3, -3, 0);                // right at the stop point
      queue_move(ACT_ADD_TRANS, 0, 0, 9);
      queue_move(ACT_TICK, 3, -3, 0);                // just inside deadband
      queue_move(ACT_ADD_TRANS, 0, 0, 1);
      queue_move(ACT_TICK, 3, -3, 0);                // exactly on deadband
      queue_move(ACT_ADD_TRANS, 0, 0, POS_MAX);
      queue_move(ACT_ADD_TRANS, 0, 0, 1);            // setpoint wrapped by the add above
      queue_move(ACT_ADD_ROT, 0, 0, POS_MIN);
      queue_move(ACT_TICK, POS_MIN, POS_MAX, 0);
      queue_move(ACT_STOP, POS_MAX, POS_MAX, 0);     // L+R wraps at stop
      queue_move(ACT_TICK, POS_MAX, POS_MAX, 0);
      queue_move(ACT_STOP, POS_MIN, POS_MAX, 0);     // L-R wraps at stop
      queue_move(ACT_TICK, POS_MIN, POS_MIN, 0);
      queue_move(ACT_TICK, POS_MAX, POS_MIN, 0);
      queue_move(ACT_TICK, -1, -1, -1);
      drain();

      // Moderate gains on both loops, full PID.
      load_settings(256, 4, 32, 512, 2, 64, 1000, 10);
      run_random(200, 64);
      drain();

      // Everything at its top value.
      load_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                    32'h7FFF, 32'hFF);
      run_random(200, 8);
      drain();

      // Everything at zero: the block can only report rest.
      load_settings(0, 0, 0, 0, 0, 0, 0, 0);
      run_random(60, 500);
      drain();

      // Raw 32-bit writes; only the register width sticks.
      load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
      run_random(250, 1000);
      drain();

      // Proportional only, wide limit, no deadband, large errors.
      load_settings(256, 0, 0, 256, 0, 0, 32'h7FFF, 0);
      run_random(250, 20000);
      drain();

      load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
      run_random(290, 16);
      drain();

      $display("Run covered %0d request transactions (%0d ticks) over %0d register settings",
               moves_accepted, ticks_accepted, settings_loaded + 1);
      $display("%0d drive transactions checked, %0d at rest, %0d mismatches",
               drives_checked, rest_seen, mismatches);
      if (mismatches == 0 && pending_drives.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
src/ddpid_pkg.sv
src/ddpid_if.sv
src/ddpid_csr.sv
src/ddpid_loop.sv
src/ddpid_mix.sv
src/differential_drive_pid_position.sv
tb/testbench.sv
